>>> hw/rtl/hrle_pkg.sv
// ---------------------------------------------------------------------------
// hrle_pkg: shared types and constants for the HEX record line encoder
// Job format between front and back, character codes, step codes.
// ---------------------------------------------------------------------------
package hrle_pkg;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;

  // Character positions within one line. A data job enters at STEP_B3_HI.
  localparam logic [3:0] STEP_COLON = 4'd0;
  localparam logic [3:0] STEP_B0_HI = 4'd1;
  localparam logic [3:0] STEP_B0_LO = 4'd2;
  localparam logic [3:0] STEP_B1_HI = 4'd3;
  localparam logic [3:0] STEP_B1_LO = 4'd4;
  localparam logic [3:0] STEP_B2_HI = 4'd5;
  localparam logic [3:0] STEP_B2_LO = 4'd6;
  localparam logic [3:0] STEP_B3_HI = 4'd7;
  localparam logic [3:0] STEP_B3_LO = 4'd8;
  localparam logic [3:0] STEP_CK_HI = 4'd9;
  localparam logic [3:0] STEP_CK_LO = 4'd10;
  localparam logic [3:0] STEP_CR    = 4'd11;
  localparam logic [3:0] STEP_LF    = 4'd12;

  // One unit of work for the back end. Data jobs carry their byte in b3.
  typedef struct packed {
    logic       is_hdr;
    logic       close;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] ck;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else begin
      c = CHAR_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/hex_record_line_encoder_top.sv
// ---------------------------------------------------------------------------
// hex_record_line_encoder_top: Intel HEX record line encoder
// Turns header and data words into the ASCII text of HEX record lines.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): a header word (in_op = 0) opens a record and yields
//   ':' plus eight hex digits for count, address high, address low and type.
//   A data word (in_op = 1) yields two hex digits. After the last data byte,
//   or right after a header with count zero, the checksum digits, CR and LF
//   follow. Data words with no open record are dropped; a header abandons
//   any open record.
//   Output channel (out_*): one character per word; out_last marks the final
//   character caused by an input word, out_record_end marks the closing LF.
// Timing:
//   The back end emits one character per cycle while the output does not
//   stall, so a data word yields two characters (six when it closes the
//   record) and a header nine (thirteen with count zero). The single
//   character output limits the sustained rate. The first character passes
//   through the job queue and then the output register. A two-entry job
//   queue lets the front accept words while the back is still printing.
// Reset: synchronous active-low rst_n closes any record and empties the queue.
// Stall: out_stall holds the output register; the queue fills, then in_stall
//   rises until a job drains.
// ---------------------------------------------------------------------------
module hex_record_line_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_count,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_record_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic        out_record_end
);

  hrle_pkg::job_t push_job;
  hrle_pkg::job_t head_job;
  logic           q_push, q_pop, q_empty, q_full;

  // Front: classify words, track the open record, build jobs.
  hrle_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_data_count   (in_data_count),
    .in_load_address (in_load_address),
    .in_record_type  (in_record_type),
    .in_data_byte    (in_data_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  // Queue: hold up to two pending jobs between front and back.
  hrle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: advance through the head job one character per unstalled cycle.
  hrle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_record_end (out_record_end)
  );

endmodule

>>> hw/rtl/hrle_front.sv
// ---------------------------------------------------------------------------
// hrle_front: record tracking front end
// Accepts items, keeps the open record state and builds jobs for the queue.
// ---------------------------------------------------------------------------
module hrle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [7:0]        in_data_count,
  input  logic [15:0]       in_load_address,
  input  logic [7:0]        in_record_type,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              q_push,
  output hrle_pkg::job_t    q_job
);

  logic [7:0] sum_r, sum_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic       open_r, open_nxt;
  logic       accept;
  logic [7:0] hsum, dsum, drem;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign hsum = in_data_count + in_load_address[15:8] + in_load_address[7:0]
              + in_record_type;
  assign dsum = sum_r + in_data_byte;
  assign drem = remain_r - 8'd1;

  always_comb begin
    sum_nxt    = sum_r;
    remain_nxt = remain_r;
    open_nxt   = open_r;
    q_push     = 1'b0;
    q_job      = '0;
    if (accept) begin
      if (!in_op) begin
        // header: abandon any open record and start over
        q_push       = 1'b1;
        q_job.is_hdr = 1'b1;
        q_job.close  = (in_data_count == 8'd0);
        q_job.b0     = in_data_count;
        q_job.b1     = in_load_address[15:8];
        q_job.b2     = in_load_address[7:0];
        q_job.b3     = in_record_type;
        q_job.ck     = 8'd0 - hsum;
        remain_nxt   = in_data_count;
        open_nxt     = (in_data_count != 8'd0);
        sum_nxt      = (in_data_count == 8'd0) ? 8'd0 : hsum;
      end else if (open_r) begin
        q_push      = 1'b1;
        q_job.close = (drem == 8'd0);
        q_job.b3    = in_data_byte;
        q_job.ck    = 8'd0 - dsum;
        remain_nxt  = drem;
        open_nxt    = (drem != 8'd0);
        sum_nxt     = (drem == 8'd0) ? 8'd0 : dsum;
      end
      // data with no open record: drop
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= 8'd0;
      remain_r <= 8'd0;
      open_r   <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      remain_r <= remain_nxt;
      open_r   <= open_nxt;
    end
  end

endmodule

>>> hw/rtl/hrle_fifo.sv
// ---------------------------------------------------------------------------
// hrle_fifo: two-entry job queue
// Decouples the front end from the character back end.
// ---------------------------------------------------------------------------
module hrle_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrle_pkg::job_t    push_job,
  input  logic              pop,
  output hrle_pkg::job_t    head_job,
  output logic              empty,
  output logic              full
);

  hrle_pkg::job_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/hrle_back.sv
// ---------------------------------------------------------------------------
// hrle_back: character back end
// Steps the head job one char per unstalled cycle into an output register.
// ---------------------------------------------------------------------------
module hrle_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hrle_pkg::job_t    head_job,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              out_last,
  output logic              out_record_end
);

  logic       active_r, active_nxt;
  logic [3:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  logic       last_r, end_r;
  logic [3:0] cur_step, end_step;
  logic [7:0] cur_char;
  logic       emit, at_end;

  assign cur_step = active_r ? step_r :
                    (head_job.is_hdr ? hrle_pkg::STEP_COLON : hrle_pkg::STEP_B3_HI);
  assign end_step = head_job.close ? hrle_pkg::STEP_LF : hrle_pkg::STEP_B3_LO;
  assign at_end   = (cur_step == end_step);
  assign emit     = !q_empty && (!valid_r || !out_stall);
  assign q_pop    = emit && at_end;

  always_comb begin
    case (cur_step)
      hrle_pkg::STEP_COLON: cur_char = hrle_pkg::CHAR_COLON;
      hrle_pkg::STEP_B0_HI: cur_char = hrle_pkg::hex_char(head_job.b0[7:4]);
      hrle_pkg::STEP_B0_LO: cur_char = hrle_pkg::hex_char(head_job.b0[3:0]);
      hrle_pkg::STEP_B1_HI: cur_char = hrle_pkg::hex_char(head_job.b1[7:4]);
      hrle_pkg::STEP_B1_LO: cur_char = hrle_pkg::hex_char(head_job.b1[3:0]);
      hrle_pkg::STEP_B2_HI: cur_char = hrle_pkg::hex_char(head_job.b2[7:4]);
      hrle_pkg::STEP_B2_LO: cur_char = hrle_pkg::hex_char(head_job.b2[3:0]);
      hrle_pkg::STEP_B3_HI: cur_char = hrle_pkg::hex_char(head_job.b3[7:4]);
      hrle_pkg::STEP_B3_LO: cur_char = hrle_pkg::hex_char(head_job.b3[3:0]);
      hrle_pkg::STEP_CK_HI: cur_char = hrle_pkg::hex_char(head_job.ck[7:4]);
      hrle_pkg::STEP_CK_LO: cur_char = hrle_pkg::hex_char(head_job.ck[3:0]);
      hrle_pkg::STEP_CR:    cur_char = hrle_pkg::CHAR_CR;
      default:              cur_char = hrle_pkg::CHAR_LF;
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    valid_nxt  = valid_r && out_stall;
    if (emit) begin
      valid_nxt  = 1'b1;
      active_nxt = !at_end;
      step_nxt   = cur_step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= cur_char;
      last_r <= at_end;
      end_r  <= (cur_step == hrle_pkg::STEP_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= hrle_pkg::STEP_COLON;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
      valid_r  <= valid_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_char       = char_r;
  assign out_last       = last_r;
  assign out_record_end = end_r;

endmodule
